[src/pls_pkg.sv]
package pls_pkg;

  // Field widths of the transaction payloads
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // Cell index field width, enough for the largest supported depth
  localparam int IDX_MAX_W = 12;
  localparam int DEPTH_DEF = 64;

  // Fan-in of each level of the removed-value OR tree
  localparam int TREE_FANIN = 8;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_HEAD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_TAIL = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_POS  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_REFUS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL_REFUS  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pls_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic                     position_adjusted;
    logic [COUNT_W-1:0]       entry_count;
  } pls_out_t;

  // Broadcast control from the sequencer to every cell of the row
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_MAX_W-1:0]  idx;
    logic [DATA_W-1:0]     value;
  } pls_ctrl_t;

  // Number of register levels in an OR tree over n leaves
  function automatic int or_tree_levels(input int n);
    int lv;
    int m;
    lv = 1;
    m  = n;
    while (m > TREE_FANIN) begin
      m  = (m + TREE_FANIN - 1) / TREE_FANIN;
      lv = lv + 1;
    end
    return lv;
  endfunction

endpackage

[src/pls_cell.sv]
module pls_cell import pls_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  pls_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] tap_o
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Insert: cells past the slot take the left neighbor, the slot takes the value.
  // Delete: the slot and everything after it take the right neighbor.
  always_comb begin
    data_nxt = data_r;
    if (ctrl_i.ins) begin
      if (MY_IDX > ctrl_i.idx) begin
        data_nxt = left_i;
      end else if (MY_IDX == ctrl_i.idx) begin
        data_nxt = ctrl_i.value;
      end
    end else if (ctrl_i.del && (MY_IDX >= ctrl_i.idx)) begin
      data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

  // Old contents of the deleted slot, zero elsewhere
  assign tap_o = (ctrl_i.del && (MY_IDX == ctrl_i.idx)) ? data_r : '0;

endmodule

[src/pls_or_tree.sv]
module pls_or_tree import pls_pkg::*; #(
  parameter int N = 8,
  parameter int W = DATA_W
) (
  input  logic                clk,
  input  logic [N-1:0][W-1:0] in_i,
  output logic [W-1:0]        out_o
);

  localparam int G = (N + TREE_FANIN - 1) / TREE_FANIN;

  logic [W-1:0]        mid_r   [G];
  logic [W-1:0]        mid_nxt [G];
  logic [G-1:0][W-1:0] mid_p;

  // One registered level: OR each group of up to TREE_FANIN leaves
  for (genvar g = 0; g < G; g++) begin : g_grp
    logic [TREE_FANIN-1:0][W-1:0] part;

    for (genvar k = 0; k < TREE_FANIN; k++) begin : g_leaf
      if (g * TREE_FANIN + k < N) begin : g_used
        assign part[k] = in_i[g * TREE_FANIN + k];
      end else begin : g_pad
        assign part[k] = '0;
      end
    end

    always_comb begin
      mid_nxt[g] = '0;
      for (int k = 0; k < TREE_FANIN; k++) begin
        mid_nxt[g] = mid_nxt[g] | part[k];
      end
    end

    always_ff @(posedge clk) begin
      mid_r[g] <= mid_nxt[g];
    end

    assign mid_p[g] = mid_r[g];
  end

  // Next level, or the root
  if (G == 1) begin : g_root
    assign out_o = mid_p[0];
  end else begin : g_next
    pls_or_tree #(.N(G), .W(W)) u_next (
      .clk  (clk),
      .in_i (mid_p),
      .out_o(out_o)
    );
  end

endmodule

[src/positional_list_store.sv]
// Results: out_strobe follows the accepting edge through the registered OR tree that
//   picks the deleted entry out of the cell row, with one register per tree level.
// Throughput: one transaction per cycle; busy stays low and results arrive in order.
// Reset clears the entry count and the result pipeline; entry contents are not
//   cleared. The receiver cannot stall: each result is shown for one cycle.
module positional_list_store import pls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pls_in_t  in_data,
  output logic     out_strobe,
  output pls_out_t out_data
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int LAT = or_tree_levels(DEPTH);

  // Entry count and result pipeline
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [LAT-1:0]      vld_r;
  logic [STATUS_W-1:0] status_r [LAT];
  logic                adj_r    [LAT];
  logic [COUNT_W-1:0]  cnt_r    [LAT];

  // Decode of the incoming transaction
  logic                accept;
  logic                mode_ok;
  logic                is_ins;
  logic                full;
  logic                empty;
  logic [EW-1:0]       cnt_e;
  logic [EW-1:0]       pos_e;
  logic [EW-1:0]       idx_e;
  logic                adj;
  logic [STATUS_W-1:0] status;
  logic                do_ins;
  logic                do_del;
  logic [31:0]         cnt_ext;
  pls_ctrl_t           ctrl;

  // Cell row
  logic [DATA_W-1:0]            cell_data [DEPTH];
  logic [DEPTH-1:0][DATA_W-1:0] tap;
  logic [DATA_W-1:0]            removed;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cnt_e  = EW'(count_r);
  assign pos_e  = EW'(in_data.position);
  assign full   = (cnt_e == EW'(DEPTH));
  assign empty  = (count_r == '0);

  // Target slot, clamping and status
  always_comb begin
    mode_ok = 1'b1;
    is_ins  = 1'b0;
    idx_e   = '0;
    adj     = 1'b0;
    status  = ST_INSERTED;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    unique case (in_data.mode)
      MODE_INS_HEAD: begin
        is_ins = 1'b1;
      end
      MODE_INS_TAIL: begin
        is_ins = 1'b1;
        idx_e  = cnt_e;
      end
      MODE_INS_POS: begin
        is_ins = 1'b1;
        if ((empty && (pos_e != EW'(1))) || (pos_e == '0)) begin
          adj = 1'b1;
        end else if (pos_e > cnt_e + EW'(1)) begin
          adj   = 1'b1;
          idx_e = cnt_e;
        end else begin
          idx_e = pos_e - EW'(1);
        end
      end
      MODE_DEL_HEAD: begin
      end
      MODE_DEL_TAIL: begin
        idx_e = cnt_e - EW'(1);
      end
      MODE_DEL_POS: begin
        if (pos_e == '0) begin
          adj = 1'b1;
        end else if (pos_e > cnt_e) begin
          adj   = 1'b1;
          idx_e = cnt_e - EW'(1);
        end else begin
          idx_e = pos_e - EW'(1);
        end
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase

    if (is_ins) begin
      if (full) begin
        status = ST_FULL_REFUS;
        adj    = 1'b0;
      end else begin
        status = ST_INSERTED;
        do_ins = accept;
      end
    end else if (empty) begin
      status = ST_EMPTY_REFUS;
      adj    = 1'b0;
    end else begin
      status = ST_REMOVED;
      do_del = accept && mode_ok;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign cnt_ext = 32'(count_nxt);

  assign ctrl.ins   = do_ins;
  assign ctrl.del   = do_del;
  assign ctrl.idx   = IDX_MAX_W'(idx_e);
  assign ctrl.value = in_data.value;

  // Row of cells, each handing its entry to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    pls_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i]),
      .tap_o  (tap[i])
    );
  end

  // Gather the deleted entry
  pls_or_tree #(.N(DEPTH), .W(DATA_W)) u_tree (
    .clk  (clk),
    .in_i (tap),
    .out_o(removed)
  );

  // Count and valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vld_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      vld_r[0] <= accept && mode_ok;
      for (int s = 1; s < LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // Result side fields, kept in step with the OR tree
  always_ff @(posedge clk) begin
    status_r[0] <= status;
    adj_r[0]    <= adj;
    cnt_r[0]    <= cnt_ext[COUNT_W-1:0];
    for (int s = 1; s < LAT; s++) begin
      status_r[s] <= status_r[s-1];
      adj_r[s]    <= adj_r[s-1];
      cnt_r[s]    <= cnt_r[s-1];
    end
  end

  assign out_strobe                 = vld_r[LAT-1];
  assign out_data.status            = status_r[LAT-1];
  assign out_data.removed_value     = removed;
  assign out_data.position_adjusted = adj_r[LAT-1];
  assign out_data.entry_count       = cnt_r[LAT-1];

endmodule

[src/pls_checker.sv]
module pls_checker import pls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input pls_in_t  in_data,
  input logic     out_strobe,
  input pls_out_t out_data
);

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

  // Nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_strobe)
    else $error("result strobe right after reset");

  // Back-to-back results: count moves by one step per insert or removal and holds on a refusal
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(out_strobe) && $past(rst_n) |->
      ((out_data.status == ST_INSERTED &&
        out_data.entry_count == COUNT_W'($past(out_data.entry_count) + 1'b1)) ||
       (out_data.status == ST_REMOVED &&
        out_data.entry_count == COUNT_W'($past(out_data.entry_count) - 1'b1)) ||
       ((out_data.status == ST_EMPTY_REFUS || out_data.status == ST_FULL_REFUS) &&
        out_data.entry_count == $past(out_data.entry_count))))
    else $error("entry count does not follow the previous result");

  // Refused transactions leave a clean result
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.status == ST_EMPTY_REFUS || out_data.status == ST_FULL_REFUS)
      |-> out_data.removed_value == '0 && !out_data.position_adjusted &&
          ((out_data.status == ST_EMPTY_REFUS && out_data.entry_count == '0) ||
           (out_data.status == ST_FULL_REFUS && out_data.entry_count == FULL_CNT)))
    else $error("refused transaction with bad fields");

  // Inserts return no value and leave a non-empty list
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status == ST_INSERTED
      |-> out_data.removed_value == '0 && out_data.entry_count != '0)
    else $error("insert result with bad fields");

endmodule

bind positional_list_store pls_checker #(.DEPTH(DEPTH)) u_pls_checker (.*);

[tb/sv/positional_list_store_tb.sv]
`timescale 1ns / 100ps

module positional_list_store_tb;
  import pls_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int RAND_OPS    = 700;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 200000;

  // Tracks the list contents, predicts each result and checks the block's output
  class list_op_scoreboard;
    logic signed [DATA_W-1:0] cells[LIST_DEPTH];
    int held;
    pls_out_t expected_results[$];
    int errors;
    int checked;
    int n_full_refused;
    int n_empty_refused;
    int n_adjusted;
    int n_removed;

    function new();
      held            = 0;
      errors          = 0;
      checked         = 0;
      n_full_refused  = 0;
      n_empty_refused = 0;
      n_adjusted      = 0;
      n_removed       = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted transaction to the list copy and queue its result
    function void note_op(pls_in_t t);
      pls_out_t r;
      int idx;
      r   = '0;
      idx = 0;
      if (t.mode > MODE_DEL_POS)
        return;
      if (t.mode <= MODE_INS_POS) begin
        if (held >= LIST_DEPTH) begin
          r.status = ST_FULL_REFUS;
        end else begin
          if (t.mode == MODE_INS_HEAD) begin
            idx = 0;
          end else if (t.mode == MODE_INS_TAIL) begin
            idx = held;
          end else if (held == 0 && t.position != 1) begin
            // positional insert into an empty list lands at the head
            idx = 0;
            r.position_adjusted = 1'b1;
          end else if (t.position < 1) begin
            idx = 0;
            r.position_adjusted = 1'b1;
          end else if (int'(t.position) > held + 1) begin
            idx = held;
            r.position_adjusted = 1'b1;
          end else begin
            idx = int'(t.position) - 1;
          end
          for (int i = held; i > idx; i--)
            cells[i] = cells[i-1];
          cells[idx] = t.value;
          held++;
          r.status = ST_INSERTED;
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY_REFUS;
        end else begin
          if (t.mode == MODE_DEL_HEAD) begin
            idx = 0;
          end else if (t.mode == MODE_DEL_TAIL) begin
            idx = held - 1;
          end else if (t.position < 1) begin
            idx = 0;
            r.position_adjusted = 1'b1;
          end else if (int'(t.position) > held) begin
            idx = held - 1;
            r.position_adjusted = 1'b1;
          end else begin
            idx = int'(t.position) - 1;
          end
          r.removed_value = cells[idx];
          for (int i = idx; i + 1 < held; i++)
            cells[i] = cells[i+1];
          held--;
          r.status = ST_REMOVED;
        end
      end
      r.entry_count = COUNT_W'(held);
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH result %0d %s: got %0d expected %0d", checked, what, got, want);
      errors++;
    endtask

    // Compare one result from the block against the oldest prediction
    task check_result(pls_out_t got);
      pls_out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, -1);
        return;
      end
      want = expected_results.pop_front();
      if (got.status != want.status)
        report_mismatch("status", got.status, want.status);
      if (got.removed_value != want.removed_value)
        report_mismatch("removed_value", got.removed_value, want.removed_value);
      if (got.position_adjusted != want.position_adjusted)
        report_mismatch("position_adjusted", got.position_adjusted, want.position_adjusted);
      if (got.entry_count != want.entry_count)
        report_mismatch("entry_count", got.entry_count, want.entry_count);
      case (want.status)
        ST_FULL_REFUS:  n_full_refused++;
        ST_EMPTY_REFUS: n_empty_refused++;
        ST_REMOVED:     n_removed++;
        default: ;
      endcase
      if (want.position_adjusted)
        n_adjusted++;
      checked++;
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  pls_in_t  in_data;
  logic     out_strobe;
  pls_out_t out_data;

  list_op_scoreboard sb;
  int cycles;
  int ops_sent;

  positional_list_store #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always #1 clk = ~clk;

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_result(out_data);
      if (start && !busy)
        sb.note_op(in_data);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("positional_list_store test failed");
      $finish;
    end
  end

  function automatic pls_in_t make_op(logic [MODE_W-1:0] m, int pos, logic [DATA_W-1:0] v);
    pls_in_t t;
    t.mode     = m;
    t.position = POS_W'(pos);
    t.value    = v;
    return t;
  endfunction

  // Hold start low for idle cycles, then present t until it is accepted
  task automatic drive_op(input pls_in_t t, input int idle);
    if (idle > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Positions mostly near the live range, with some below one and far past the end
  function automatic int pick_position(int held);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(0, 255);
      2:       return held + $urandom_range(1, 2);
      default: return $urandom_range(1, held + 1);
    endcase
  endfunction

  task automatic send_random(input int ins_pct, input bit no_idle, output bit counted);
    logic [MODE_W-1:0] m;
    int idle;
    counted = 1'b1;
    if ($urandom_range(0, 49) == 0) begin
      // unused opcodes, no result expected
      m = $urandom_range(0, 1) ? 3'd6 : 3'd7;
      counted = 1'b0;
    end else if ($urandom_range(1, 100) <= ins_pct) begin
      case ($urandom_range(0, 2))
        0:       m = MODE_INS_HEAD;
        1:       m = MODE_INS_TAIL;
        default: m = MODE_INS_POS;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       m = MODE_DEL_HEAD;
        1:       m = MODE_DEL_TAIL;
        default: m = MODE_DEL_POS;
      endcase
    end
    idle = no_idle ? 0 : $urandom_range(0, 7);
    drive_op(make_op(m, pick_position(sb.held), pick_value()), idle);
  endtask

  initial begin
    bit counted;
    int phase;
    int phase_len;
    int ins_pct;
    bit no_idle;

    sb       = new();
    clk      = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    cycles   = 0;
    ops_sent = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty refusals, clamping in both directions, extremes, unused opcodes
    drive_op(make_op(MODE_DEL_HEAD, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_TAIL, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_POS, 3, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_POS, 0, 32'h8000_0000), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_POS, 1, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_POS, 1, 32'h7FFF_FFFF), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_POS, 200, 32'hFFFF_FFFF), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_HEAD, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_TAIL, 0, 32'h5555_5555), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_POS, 2, 32'hAAAA_AAAA), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_POS, 0, 32'h1), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_POS, 7, 32'h2), $urandom_range(0, 7));
    drive_op(make_op(3'd6, 255, 32'hFFFF_FFFF), $urandom_range(0, 7));
    drive_op(make_op(3'd7, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_POS, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_POS, 255, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_POS, 5, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_POS, 2, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_HEAD, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_TAIL, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_HEAD, 255, 32'h8000_0000), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_TAIL, 0, 32'hFFFF_FFFF), $urandom_range(0, 7));
    drive_op(make_op(MODE_DEL_HEAD, 0, 32'h0), $urandom_range(0, 7));
    drive_op(make_op(MODE_INS_POS, 255, 32'h1234_5678), $urandom_range(0, 7));

    // Random: alternate fill, drain and mixed phases so the list hits full and empty
    phase = 0;
    while (ops_sent < RAND_OPS) begin
      case (phase % 3)
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      phase_len = $urandom_range(40, 100);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && ops_sent < RAND_OPS; k++) begin
        send_random(ins_pct, no_idle, counted);
        if (counted)
          ops_sent++;
      end
      phase++;
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain outstanding results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d random operations over %0d phases; %0d results checked",
             ops_sent, phase, sb.checked);
    $display("removed %0d, clamped %0d, full refusals %0d, empty refusals %0d",
             sb.n_removed, sb.n_adjusted, sb.n_full_refused, sb.n_empty_refused);
    if (sb.errors == 0) begin
      $display("positional_list_store test passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("positional_list_store test failed");
    end
    $finish;
  end

endmodule
